// ===== hdl/idll_pkg.sv =====
// shared constants, codes and control structs of the indexed linked list unit
package idll_pkg;

   // default sizing
   localparam int NODES_DEFAULT      = 256;
   localparam int VALUE_BITS_DEFAULT = 32;

   // item field widths
   localparam int CMD_W    = 3;
   localparam int VALUE_W  = 32;
   localparam int REF_W    = 8;
   localparam int NODE_W   = 8;
   localparam int STATUS_W = 2;

   // command codes
   localparam logic [CMD_W-1:0] CMD_INS_AFTER  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_INS_BEFORE = 3'd1;
   localparam logic [CMD_W-1:0] CMD_RMV_AFTER  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_RMV_BEFORE = 3'd3;
   localparam logic [CMD_W-1:0] CMD_RMV_NODE   = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_SENTINEL = 2'd2;

   // sequencer to slot manager
   typedef struct packed {
      logic pop;
      logic push;
   } slot_ctl_type;

   // slot manager to sequencer
   typedef struct packed {
      logic has_free;
      logic has_unused;
   } slot_sts_type;

endpackage

// ===== hdl/idll_if.sv =====
// request and response channel interfaces of the indexed linked list unit
interface idll_req_if import idll_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    cmd;
   logic [VALUE_W-1:0]  value;
   logic [REF_W-1:0]    ref_node;

   modport source (output valid, output cmd, output value, output ref_node, input ready);
   modport sink   (input valid, input cmd, input value, input ref_node, output ready);
endinterface

interface idll_rsp_if import idll_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [NODE_W-1:0]   node;
   logic [STATUS_W-1:0] status;

   modport source (output valid, output node, output status, input ready);
   modport sink   (input valid, input node, input status, output ready);
endinterface

// ===== hdl/indexed_doubly_linked_list_unit.sv =====
// Circular doubly linked list held in index-addressed next, previous and value memories,
// with node 0 as a sentinel and a free stack of released slots. Each request item
// (insert after, insert before, remove after, remove before, remove node) returns one
// response item with the node index and a status (ok, list full, sentinel target).
// An item first reads the links of its reference; an insert or a remove node then ends
// in the link state, remove after and remove before in a later release state, and full,
// sentinel or unknown commands already in the read state. The link memories have a
// registered read, so each pointer chase costs a state before the dependent write. The
// next request is accepted in the cycle after a result enters the output register, even
// while it still waits there; a result meeting a full register is parked in a hold state
// until free. ref_node is taken modulo NODES. No clearing pass is needed after reset.
module indexed_doubly_linked_list_unit import idll_pkg::*; #(
   parameter int NODES      = NODES_DEFAULT,
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
   input logic         clock,
   input logic         reset,
   idll_req_if.sink    req_ch,
   idll_rsp_if.source  rsp_ch
);

   localparam int IDX_W = $clog2(NODES);

   logic [REF_W-1:0] ref_rem;
   logic [IDX_W-1:0] ref_idx;
   slot_ctl_type     slot_ctl;
   slot_sts_type     slot_sts;
   logic [IDX_W-1:0] slot_push_node;
   logic [IDX_W-1:0] slot_node;

   // reference index modulo the node count, by shifted compare and subtract
   always_comb begin
      ref_rem = req_ch.ref_node;
      for (int k = REF_W - 1; k >= 0; k--) begin
         if (int'(ref_rem) >= (NODES << k)) begin
            ref_rem = ref_rem - REF_W'(NODES << k);
         end
      end
   end

   assign ref_idx = IDX_W'(ref_rem);

   idll_ctrl #(
      .NODES      (NODES),
      .VALUE_BITS (VALUE_BITS)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_ch.valid),
      .req_ready      (req_ch.ready),
      .req_cmd        (req_ch.cmd),
      .req_value      (req_ch.value),
      .req_ref        (ref_idx),
      .rsp_valid      (rsp_ch.valid),
      .rsp_ready      (rsp_ch.ready),
      .rsp_node       (rsp_ch.node),
      .rsp_status     (rsp_ch.status),
      .slot_ctl       (slot_ctl),
      .slot_push_node (slot_push_node),
      .slot_sts       (slot_sts),
      .slot_node      (slot_node)
   );

   idll_slots #(
      .NODES (NODES)
   ) u_slots (
      .clock     (clock),
      .reset     (reset),
      .slot_ctl  (slot_ctl),
      .push_node (slot_push_node),
      .slot_sts  (slot_sts),
      .slot_node (slot_node)
   );

endmodule

// ===== hdl/idll_ram.sv =====
// generic simple dual port ram, one write and one registered read port
module idll_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write, then registered read of the old contents
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// ===== hdl/idll_slots.sv =====
// free slot manager: free stack memory, stack depth and never-used mark
module idll_slots import idll_pkg::*; #(
   parameter int NODES = NODES_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  slot_ctl_type             slot_ctl,
   input  logic [$clog2(NODES)-1:0] push_node,
   output slot_sts_type             slot_sts,
   output logic [$clog2(NODES)-1:0] slot_node
);

   localparam int IDX_W = $clog2(NODES);
   localparam int CNT_W = $clog2(NODES + 1);

   logic [CNT_W-1:0] free_count_ff, free_count_in;
   logic [CNT_W-1:0] used_end_ff, used_end_in;
   logic             stack_we;
   logic [IDX_W-1:0] stack_top;

   // status
   assign slot_sts.has_free   = (free_count_ff != '0);
   assign slot_sts.has_unused = (used_end_ff < CNT_W'(NODES));

   // top of stack is always being read
   assign stack_we = slot_ctl.push && (free_count_ff < CNT_W'(NODES));

   idll_ram #(
      .WIDTH (IDX_W),
      .DEPTH (NODES)
   ) u_stack (
      .clock (clock),
      .we    (stack_we),
      .waddr (free_count_ff[IDX_W-1:0]),
      .wdata (push_node),
      .raddr (IDX_W'(free_count_ff - CNT_W'(1))),
      .rdata (stack_top)
   );

   // slot offered to an insert
   assign slot_node = slot_sts.has_free ? stack_top : used_end_ff[IDX_W-1:0];

   // count updates
   always_comb begin
      free_count_in = free_count_ff;
      used_end_in   = used_end_ff;
      if (slot_ctl.pop) begin
         if (slot_sts.has_free) begin
            free_count_in = free_count_ff - CNT_W'(1);
         end else if (slot_sts.has_unused) begin
            used_end_in = used_end_ff + CNT_W'(1);
         end
      end else if (stack_we) begin
         free_count_in = free_count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_count_ff <= '0;
         used_end_ff   <= CNT_W'(1);
      end else begin
         free_count_ff <= free_count_in;
         used_end_ff   <= used_end_in;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      free_count_ff <= CNT_W'(NODES))
      else $error("free stack depth beyond capacity");

   a_used_end_floor: assert property (@(posedge clock) disable iff (reset)
      used_end_ff != '0)
      else $error("never-used mark reached the sentinel");

   a_no_pop_push: assert property (@(posedge clock) disable iff (reset)
      !(slot_ctl.pop && slot_ctl.push))
      else $error("pop and push in one cycle");

endmodule

// ===== hdl/idll_ctrl.sv =====
// command sequencer with the next, previous and value memories
module idll_ctrl import idll_pkg::*; #(
   parameter int NODES      = NODES_DEFAULT,
   parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [CMD_W-1:0]         req_cmd,
   input  logic [VALUE_W-1:0]       req_value,
   input  logic [$clog2(NODES)-1:0] req_ref,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [NODE_W-1:0]        rsp_node,
   output logic [STATUS_W-1:0]      rsp_status,
   output slot_ctl_type             slot_ctl,
   output logic [$clog2(NODES)-1:0] slot_push_node,
   input  slot_sts_type             slot_sts,
   input  logic [$clog2(NODES)-1:0] slot_node
);

   localparam int IDX_W = $clog2(NODES);

   typedef enum logic [2:0] {
      S_IDLE,
      S_RD,
      S_LINK,
      S_FREE,
      S_HOLD
   } state_type;

   state_type             state_ff, state_in;
   logic [CMD_W-1:0]      cmd_ff, cmd_in;
   logic [VALUE_W-1:0]    value_ff, value_in;
   logic [IDX_W-1:0]      r_ff, r_in;
   logic [IDX_W-1:0]      n_ff, n_in;
   logic [IDX_W-1:0]      a_ff, a_in;
   logic [NODE_W-1:0]     res_node_ff, res_node_in;
   logic [STATUS_W-1:0]   res_status_ff, res_status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [NODE_W-1:0]     rsp_node_ff, rsp_node_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic                  next0_ok_ff, next0_ok_in;
   logic                  prev0_ok_ff, prev0_ok_in;
   logic                  nrd_zero_ff, nrd_zero_in;
   logic                  prd_zero_ff, prd_zero_in;

   logic                  nwe, pwe, vwe;
   logic [IDX_W-1:0]      nwa, nwd, pwa, pwd, vwa;
   logic [IDX_W-1:0]      next_ra, prev_ra;
   logic [IDX_W-1:0]      next_rdata, prev_rdata;
   logic [IDX_W-1:0]      nrd, prd, x_node;
   logic                  done;
   logic [NODE_W-1:0]     fin_node;
   logic [STATUS_W-1:0]   fin_status;
   logic                  out_free;

   // link and value memories
   idll_ram #(.WIDTH (IDX_W), .DEPTH (NODES)) u_next (
      .clock (clock), .we (nwe), .waddr (nwa), .wdata (nwd),
      .raddr (next_ra), .rdata (next_rdata)
   );

   idll_ram #(.WIDTH (IDX_W), .DEPTH (NODES)) u_prev (
      .clock (clock), .we (pwe), .waddr (pwa), .wdata (pwd),
      .raddr (prev_ra), .rdata (prev_rdata)
   );

   idll_ram #(.WIDTH (VALUE_BITS), .DEPTH (NODES)) u_value (
      .clock (clock), .we (vwe), .waddr (vwa), .wdata (VALUE_BITS'(value_ff)),
      .raddr ('0), .rdata ()
   );

   // sentinel links read as zero until first written
   assign nrd = nrd_zero_ff ? '0 : next_rdata;
   assign prd = prd_zero_ff ? '0 : prev_rdata;

   // new node's successor (insert after) or predecessor (insert before)
   assign x_node = (n_ff == r_ff) ? n_ff : a_ff;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);

   // sequencer
   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      value_in       = value_ff;
      r_in           = r_ff;
      n_in           = n_ff;
      a_in           = a_ff;
      res_node_in    = res_node_ff;
      res_status_in  = res_status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_node_in    = rsp_node_ff;
      rsp_status_in  = rsp_status_ff;
      nwe            = 1'b0;
      nwa            = '0;
      nwd            = '0;
      pwe            = 1'b0;
      pwa            = '0;
      pwd            = '0;
      vwe            = 1'b0;
      vwa            = '0;
      next_ra        = '0;
      prev_ra        = '0;
      slot_ctl       = '0;
      slot_push_node = n_ff;
      done           = 1'b0;
      fin_node       = '0;
      fin_status     = ST_OK;

      case (state_ff)
         S_IDLE: begin
            next_ra = req_ref;
            prev_ra = req_ref;
            if (req_valid) begin
               cmd_in   = req_cmd;
               value_in = req_value;
               r_in     = req_ref;
               state_in = S_RD;
            end
         end

         // links of the reference are here
         S_RD: begin
            case (cmd_ff)
               CMD_INS_AFTER, CMD_INS_BEFORE: begin
                  if (!slot_sts.has_free && !slot_sts.has_unused) begin
                     done       = 1'b1;
                     fin_status = ST_FULL;
                  end else begin
                     slot_ctl.pop = 1'b1;
                     n_in = slot_node;
                     vwe  = 1'b1;
                     vwa  = slot_node;
                     nwe  = 1'b1;
                     nwa  = slot_node;
                     pwe  = 1'b1;
                     pwa  = slot_node;
                     if (cmd_ff == CMD_INS_AFTER) begin
                        nwd  = nrd;
                        pwd  = r_ff;
                        a_in = nrd;
                     end else begin
                        pwd  = prd;
                        nwd  = r_ff;
                        a_in = prd;
                     end
                     state_in = S_LINK;
                  end
               end
               CMD_RMV_AFTER: begin
                  n_in    = nrd;
                  next_ra = nrd;
                  if (nrd == '0) begin
                     done       = 1'b1;
                     fin_status = ST_SENTINEL;
                  end else begin
                     state_in = S_LINK;
                  end
               end
               CMD_RMV_BEFORE: begin
                  n_in    = prd;
                  prev_ra = prd;
                  if (prd == '0) begin
                     done       = 1'b1;
                     fin_status = ST_SENTINEL;
                  end else begin
                     state_in = S_LINK;
                  end
               end
               CMD_RMV_NODE: begin
                  n_in = r_ff;
                  if (r_ff == '0) begin
                     done       = 1'b1;
                     fin_status = ST_SENTINEL;
                  end else begin
                     nwe      = 1'b1;
                     nwa      = prd;
                     nwd      = nrd;
                     pwe      = 1'b1;
                     pwa      = nrd;
                     pwd      = prd;
                     state_in = S_LINK;
                  end
               end
               default: begin
                  done = 1'b1;
               end
            endcase
         end

         // second insert link writes, unlinks, remove node release
         S_LINK: begin
            case (cmd_ff)
               CMD_INS_AFTER: begin
                  nwe        = 1'b1;
                  nwa        = r_ff;
                  nwd        = n_ff;
                  pwe        = 1'b1;
                  pwa        = x_node;
                  pwd        = n_ff;
                  done       = 1'b1;
                  fin_node   = NODE_W'(n_ff);
               end
               CMD_INS_BEFORE: begin
                  pwe        = 1'b1;
                  pwa        = r_ff;
                  pwd        = n_ff;
                  nwe        = 1'b1;
                  nwa        = x_node;
                  nwd        = n_ff;
                  done       = 1'b1;
                  fin_node   = NODE_W'(n_ff);
               end
               CMD_RMV_AFTER: begin
                  nwe      = 1'b1;
                  nwa      = r_ff;
                  nwd      = nrd;
                  pwe      = 1'b1;
                  pwa      = nrd;
                  pwd      = r_ff;
                  state_in = S_FREE;
               end
               CMD_RMV_BEFORE: begin
                  pwe      = 1'b1;
                  pwa      = r_ff;
                  pwd      = prd;
                  nwe      = 1'b1;
                  nwa      = prd;
                  nwd      = r_ff;
                  state_in = S_FREE;
               end
               default: begin
                  // remove node: release the slot
                  nwe           = 1'b1;
                  nwa           = n_ff;
                  nwd           = n_ff;
                  pwe           = 1'b1;
                  pwa           = n_ff;
                  pwd           = n_ff;
                  slot_ctl.push = 1'b1;
                  done          = 1'b1;
                  fin_node      = NODE_W'(n_ff);
               end
            endcase
         end

         // release of the removed slot
         S_FREE: begin
            nwe           = 1'b1;
            nwa           = n_ff;
            nwd           = n_ff;
            pwe           = 1'b1;
            pwa           = n_ff;
            pwd           = n_ff;
            slot_ctl.push = 1'b1;
            done          = 1'b1;
            fin_node      = NODE_W'(n_ff);
         end

         S_HOLD: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_node_in   = res_node_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // hand the result to the output register, or park it
      if (done) begin
         res_node_in   = fin_node;
         res_status_in = fin_status;
         if (out_free) begin
            rsp_valid_in  = 1'b1;
            rsp_node_in   = fin_node;
            rsp_status_in = fin_status;
            state_in      = S_IDLE;
         end else begin
            state_in = S_HOLD;
         end
      end
   end

   // sentinel entry tracking
   assign next0_ok_in = next0_ok_ff || (nwe && (nwa == '0));
   assign prev0_ok_in = prev0_ok_ff || (pwe && (pwa == '0));
   assign nrd_zero_in = (next_ra == '0) && !next0_ok_ff;
   assign prd_zero_in = (prev_ra == '0) && !prev0_ok_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         next0_ok_ff  <= 1'b0;
         prev0_ok_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         next0_ok_ff  <= next0_ok_in;
         prev0_ok_ff  <= prev0_ok_in;
      end
      cmd_ff        <= cmd_in;
      value_ff      <= value_in;
      r_ff          <= r_in;
      n_ff          <= n_in;
      a_ff          <= a_in;
      res_node_ff   <= res_node_in;
      res_status_ff <= res_status_in;
      rsp_node_ff   <= rsp_node_in;
      rsp_status_ff <= rsp_status_in;
      nrd_zero_ff   <= nrd_zero_in;
      prd_zero_ff   <= prd_zero_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_node   = rsp_node_ff;
   assign rsp_status = rsp_status_ff;

   a_hold_occupied: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_HOLD |-> rsp_valid_ff)
      else $error("result parked while output register is empty");

   a_accept_to_read: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == S_RD)
      else $error("accepted item did not start its read");

   a_pop_has_slot: assert property (@(posedge clock) disable iff (reset)
      slot_ctl.pop |-> slot_sts.has_free || slot_sts.has_unused)
      else $error("slot taken from a full list");

   a_push_nonzero: assert property (@(posedge clock) disable iff (reset)
      slot_ctl.push |-> slot_push_node != '0)
      else $error("sentinel pushed onto the free stack");

endmodule

// ===== test/tb_indexed_doubly_linked_list_unit.sv =====
// testbench of the indexed doubly linked list unit: list predictor, directed and random items
module tb_indexed_doubly_linked_list_unit import idll_pkg::*; ();

   localparam int NODE_COUNT   = NODES_DEFAULT;
   localparam int RANDOM_ITEMS = 450;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int FULL_HITS    = 5;
   localparam int MAX_REPORTS  = 10;

   // command codes the block does not know
   localparam logic [CMD_W-1:0] CMD_UNKNOWN_LO = 3'd5;
   localparam logic [CMD_W-1:0] CMD_UNKNOWN_HI = 3'd7;

   typedef struct packed {
      logic [NODE_W-1:0]   node;
      logic [STATUS_W-1:0] status;
   } link_rsp_type;

   // list predictor and store of expected responses
   class list_scoreboard;
      logic [NODE_W-1:0]  next_link [NODE_COUNT];
      logic [NODE_W-1:0]  prev_link [NODE_COUNT];
      logic [VALUE_W-1:0] stored_value [NODE_COUNT];
      logic [NODE_W-1:0]  free_slots [NODE_COUNT];
      int unsigned        free_top;
      int unsigned        first_unused;
      int unsigned        full_seen;
      int unsigned        mismatches;
      link_rsp_type       expected_rsp [$];

      function new();
         for (int i = 0; i < NODE_COUNT; i++) begin
            next_link[i]    = '0;
            prev_link[i]    = '0;
            stored_value[i] = '0;
            free_slots[i]   = '0;
         end
         free_top     = 0;
         first_unused = 1;
         full_seen    = 0;
         mismatches   = 0;
      endfunction

      // pop the free stack first, else hand out the next never-used slot
      function bit take_slot(output int unsigned slot);
         slot = 0;
         if (free_top > 0) begin
            free_top--;
            slot = free_slots[free_top] % NODE_COUNT;
            return 1'b1;
         end
         if (first_unused < NODE_COUNT) begin
            slot = first_unused;
            first_unused++;
            return 1'b1;
         end
         return 1'b0;
      endfunction

      // a push onto a full stack is dropped, the links still point at the node itself
      function void release_slot(int unsigned slot);
         if (free_top < NODE_COUNT) begin
            free_slots[free_top] = NODE_W'(slot);
            free_top++;
         end
         next_link[slot] = NODE_W'(slot);
         prev_link[slot] = NODE_W'(slot);
      endfunction

      function int pending();
         return expected_rsp.size();
      endfunction

      // apply one accepted request to the list and queue its response
      function void note(logic [CMD_W-1:0] cmd, logic [VALUE_W-1:0] value,
                         logic [REF_W-1:0] ref_node);
         int unsigned  anchor;
         int unsigned  slot;
         link_rsp_type rsp;
         anchor     = ref_node % NODE_COUNT;
         slot       = 0;
         rsp.status = ST_OK;
         case (cmd)
            CMD_INS_AFTER, CMD_INS_BEFORE: begin
               if (!take_slot(slot)) begin
                  slot       = 0;
                  rsp.status = ST_FULL;
                  full_seen++;
               end else begin
                  stored_value[slot] = value;
                  if (cmd == CMD_INS_AFTER) begin
                     next_link[slot]            = next_link[anchor];
                     next_link[anchor]          = NODE_W'(slot);
                     prev_link[slot]            = NODE_W'(anchor);
                     prev_link[next_link[slot]] = NODE_W'(slot);
                  end else begin
                     prev_link[slot]            = prev_link[anchor];
                     prev_link[anchor]          = NODE_W'(slot);
                     next_link[slot]            = NODE_W'(anchor);
                     next_link[prev_link[slot]] = NODE_W'(slot);
                  end
               end
            end
            CMD_RMV_AFTER: begin
               slot = 32'(next_link[anchor]);
               if (slot == 0) begin
                  rsp.status = ST_SENTINEL;
               end else begin
                  next_link[anchor]          = next_link[slot];
                  prev_link[next_link[slot]] = NODE_W'(anchor);
                  release_slot(slot);
               end
            end
            CMD_RMV_BEFORE: begin
               slot = 32'(prev_link[anchor]);
               if (slot == 0) begin
                  rsp.status = ST_SENTINEL;
               end else begin
                  prev_link[anchor]          = prev_link[slot];
                  next_link[prev_link[slot]] = NODE_W'(anchor);
                  release_slot(slot);
               end
            end
            CMD_RMV_NODE: begin
               slot = anchor;
               if (slot == 0) begin
                  rsp.status = ST_SENTINEL;
               end else begin
                  next_link[prev_link[slot]] = next_link[slot];
                  prev_link[next_link[slot]] = prev_link[slot];
                  release_slot(slot);
               end
            end
            default: ;
         endcase
         rsp.node = NODE_W'(slot);
         expected_rsp.push_back(rsp);
      endfunction

      // compare one response item against the oldest expectation
      function void check(logic [NODE_W-1:0] node, logic [STATUS_W-1:0] status);
         link_rsp_type want;
         if (expected_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected response: node %0d status %0d", node, status);
            return;
         end
         want = expected_rsp.pop_front();
         if (node !== want.node || status !== want.status) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("mismatch: expected node %0d status %0d, got node %0d status %0d",
                        want.node, want.status, node, status);
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   idll_req_if req_ch ();
   idll_rsp_if rsp_ch ();

   indexed_doubly_linked_list_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   list_scoreboard sb;

   int          cycle_count;
   int          send_left;
   bit          send_quiet;
   int          rsp_left;
   bit          rsp_quiet;
   int          rsp_stall;
   int unsigned chain [$];

   // clock
   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // wait drawn per item, in stretches that are either quiet or idle-prone
   function automatic int draw_wait(inout int left, inout bit quiet);
      if (left == 0) begin
         left  = $urandom_range(5, 40);
         quiet = ($urandom_range(0, 3) == 0);
      end
      left--;
      return quiet ? 0 : $urandom_range(0, 10);
   endfunction

   // linked node from the walk of the list, or the sentinel
   function automatic logic [REF_W-1:0] pick_anchor(bit allow_sentinel);
      if (chain.size() == 0 || (allow_sentinel && $urandom_range(0, 9) == 0))
         return '0;
      return REF_W'(chain[$urandom_range(0, chain.size() - 1)]);
   endfunction

   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // present one request item and hold it until accepted
   task automatic send_item(logic [CMD_W-1:0] cmd, logic [VALUE_W-1:0] value,
                            logic [REF_W-1:0] ref_node);
      int gap;
      gap = draw_wait(send_left, send_quiet);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.cmd      <= cmd;
      req_ch.value    <= value;
      req_ch.ref_node <= ref_node;
      do @(posedge clock); while (!req_ch.ready);
      sb.note(cmd, value, ref_node);
   endtask

   // hold off the sender until every response is in
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // response side: check accepted items, stall ready at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_stall = 0;
      end else if (rsp_ch.valid && rsp_ch.ready) begin
         sb.check(rsp_ch.node, rsp_ch.status);
         rsp_stall = draw_wait(rsp_left, rsp_quiet);
         rsp_ch.ready <= (rsp_stall == 0);
      end else if (!rsp_ch.ready) begin
         if (rsp_stall > 0)
            rsp_stall--;
         rsp_ch.ready <= (rsp_stall == 0);
      end
   end

   // timeout
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // stimulus
   initial begin
      bit               growing;
      logic [CMD_W-1:0] cmd;
      logic [REF_W-1:0] anchor;
      int unsigned      cur;
      int               roll;
      int               ins_share;

      sb              = new();
      cycle_count     = 0;
      send_left       = 0;
      send_quiet      = 1'b0;
      rsp_left        = 0;
      rsp_quiet       = 1'b0;
      rsp_stall       = 0;
      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.cmd      = CMD_INS_AFTER;
      req_ch.value    = '0;
      req_ch.ref_node = '0;
      rsp_ch.ready    = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // removes on the empty list hit the sentinel
      send_item(CMD_RMV_AFTER, '0, '0);
      send_item(CMD_RMV_BEFORE, '0, '0);
      send_item(CMD_RMV_NODE, '1, '0);
      // unknown commands change nothing
      for (int c = CMD_UNKNOWN_LO; c <= CMD_UNKNOWN_HI; c++)
         send_item(CMD_W'(c), '1, '1);
      // build a short list on both sides of the sentinel and of node one
      send_item(CMD_INS_AFTER, 32'h0000_0000, 8'd0);
      send_item(CMD_INS_BEFORE, 32'hFFFF_FFFF, 8'd0);
      send_item(CMD_INS_AFTER, 32'h8000_0001, 8'd1);
      send_item(CMD_INS_BEFORE, 32'h7FFF_FFFE, 8'd1);
      // every remove flavor, then reuse of a freed slot
      send_item(CMD_RMV_AFTER, '0, 8'd1);
      send_item(CMD_RMV_BEFORE, '0, 8'd1);
      send_item(CMD_RMV_NODE, '0, 8'd1);
      send_item(CMD_INS_AFTER, 32'h1234_5678, 8'd2);
      send_item(CMD_RMV_BEFORE, '0, 8'd0);
      // remove through a node that is already freed
      send_item(CMD_RMV_AFTER, '0, 8'd4);
      send_item(CMD_INS_BEFORE, 32'hDEAD_BEEF, 8'd0);
      wait_drained();

      // random: grow until the list reports full a few times, then drain it
      growing = 1'b1;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         chain.delete();
         cur = 32'(sb.next_link[0]);
         while (cur != 0 && chain.size() < NODE_COUNT) begin
            chain.push_back(cur);
            cur = 32'(sb.next_link[cur]);
         end
         if (!growing && chain.size() == 0)
            growing = 1'b1;

         roll      = $urandom_range(0, 99);
         ins_share = growing ? 86 : 20;
         if (roll < 4) begin
            // noise: unknown commands, freed references, sentinel references
            case ($urandom_range(0, 2))
               0: begin
                  cmd    = CMD_W'($urandom_range(CMD_UNKNOWN_LO, CMD_UNKNOWN_HI));
                  anchor = REF_W'($urandom);
               end
               1: begin
                  cmd = CMD_W'($urandom_range(CMD_INS_AFTER, CMD_RMV_NODE));
                  if (sb.free_top > 0)
                     anchor = sb.free_slots[$urandom_range(0, sb.free_top - 1)];
                  else
                     anchor = '0;
               end
               default: begin
                  cmd    = CMD_W'($urandom_range(CMD_RMV_AFTER, CMD_RMV_NODE));
                  anchor = '0;
               end
            endcase
         end else if (roll < 4 + ins_share) begin
            cmd    = $urandom_range(0, 1) ? CMD_INS_BEFORE : CMD_INS_AFTER;
            anchor = pick_anchor(1'b1);
         end else begin
            case ($urandom_range(0, 2))
               0:       cmd = CMD_RMV_AFTER;
               1:       cmd = CMD_RMV_BEFORE;
               default: cmd = CMD_RMV_NODE;
            endcase
            anchor = pick_anchor(cmd != CMD_RMV_NODE);
         end
         send_item(cmd, pick_value(), anchor);

         if (growing && sb.full_seen >= FULL_HITS) begin
            growing = 1'b0;
            wait_drained();
         end
      end

      wait_drained();
      repeat (12) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== indexed_doubly_linked_list_unit.f =====
hdl/idll_pkg.sv
hdl/idll_if.sv
hdl/idll_ram.sv
hdl/idll_slots.sv
hdl/idll_ctrl.sv
hdl/indexed_doubly_linked_list_unit.sv
test/tb_indexed_doubly_linked_list_unit.sv
